// ===== sv/siq_pkg.sv =====
// Package for the sorted insertion queue: sizes, status and request codes,
// and the circular index helper. No dependencies.
`timescale 1ns / 1ps

package siq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int VAL_W   = 32;
	localparam int HELD_W  = 5;
	localparam int STAT_W  = 2;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// head + offset, wrapped into the ring (the single wrap is right for offsets up to DEPTH)
	function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return IDX_W'(sum);
	endfunction

endpackage

// ===== sv/siq_if.sv =====
// Request and response channel interfaces for the sorted insertion queue.
// Depends on siq_pkg.
`timescale 1ns / 1ps

interface siq_req_if;
	import siq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, req_type, value, input ready);
	modport sink   (input valid, req_type, value, output ready);
endinterface

interface siq_rsp_if;
	import siq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] removed_value;
	logic [HELD_W-1:0]       held_count;

	modport source (output valid, status, removed_value, held_count, input ready);
	modport sink   (input valid, status, removed_value, held_count, output ready);
endinterface

// ===== sv/sorted_insertion_queue_core.sv =====
// An insert shifts each held value greater than the new one up by one ring entry
// (one ring entry moved per cycle) before the new value is written; a remove passes
// through S_RMV, a refused request goes straight to S_DONE. One request is in flight at a time.
// The response register lets the next request in while a response waits.
// Values sit in a ring memory with a registered read port; reset clears count,
// head and control, memory contents are left as they are.
`timescale 1ns / 1ps

module sorted_insertion_queue_core
	import siq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	siq_req_if.sink   req,
	siq_rsp_if.source rsp
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_WRV  = 3'd2;
	localparam logic [2:0] S_RMV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        head_q;
	logic [CNT_W-1:0]        k_q;
	logic signed [VAL_W-1:0] v_q;
	logic [STAT_W-1:0]       status_q;
	logic signed [VAL_W-1:0] taken_q;

	logic                    rsp_valid_q;
	logic [STAT_W-1:0]       rsp_status_q;
	logic signed [VAL_W-1:0] rsp_value_q;
	logic [HELD_W-1:0]       rsp_count_q;

	logic [VAL_W-1:0]        entry_mem_q [DEPTH];
	logic [VAL_W-1:0]        rd_data_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic [VAL_W-1:0]        mem_wdata;
	logic                    mem_re;
	logic [IDX_W-1:0]        mem_raddr;

	logic                    req_xfer;
	logic                    shift_up;
	logic                    rsp_free;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign shift_up  = $signed(rd_data_q) > v_q;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.removed_value = rsp_value_q;
	assign rsp.held_count    = rsp_count_q;

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ring_idx(head_q, k_q);
		mem_wdata = v_q;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					mem_re = 1'b1;
					if (req.req_type == REQ_INSERT) begin
						mem_raddr = ring_idx(head_q, count_q - CNT_W'(1));
					end
				end
			end
			S_CMP: begin
				mem_we = 1'b1;
				if (shift_up) begin
					mem_wdata = rd_data_q;
					mem_re    = (k_q != CNT_W'(1));
					mem_raddr = ring_idx(head_q, k_q - CNT_W'(2));
				end
			end
			S_WRV: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= entry_mem_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// in S_DONE the load below decides rsp_valid_q on its own
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						v_q      <= req.value;
						status_q <= ST_DONE;
						taken_q  <= '0;
						if (req.req_type == REQ_INSERT) begin
							if (count_q == CNT_W'(DEPTH)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (count_q == '0) begin
								k_q     <= '0;
								state_q <= S_WRV;
							end else begin
								k_q     <= count_q;
								state_q <= S_CMP;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_RMV;
							end
						end
					end
				end
				S_CMP: begin
					if (shift_up) begin
						k_q <= k_q - CNT_W'(1);
						if (k_q == CNT_W'(1)) begin
							state_q <= S_WRV;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_WRV: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_RMV: begin
					taken_q <= rd_data_q;
					head_q  <= ring_idx(head_q, CNT_W'(1));
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_value_q  <= taken_q;
						rsp_count_q  <= HELD_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
